/* hdl/tdpt_pkg.sv */
// Shared constants and types for the trial-division prime test.
`default_nettype none
package tdpt_pkg;

    // Width of the signed candidate word.
    localparam int VALUE_BITS = 32;
    // Magnitude bits of a non-negative candidate.
    localparam int N_BITS     = VALUE_BITS - 1;
    // Trial divisors never pass the square root of the candidate plus two.
    localparam int D_BITS     = VALUE_BITS / 2 + 1;
    // Running square of the divisor.
    localparam int SQ_BITS    = 2 * D_BITS;
    // Step counter of the serial remainder unit.
    localparam int CNT_BITS   = $clog2(N_BITS + 1);
    // tdata widths, rounded up to whole bytes.
    localparam int S_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 8;

    // Status from the remainder unit to the sequencer.
    typedef struct packed {
        logic done;
        logic zero;
    } mod_status_t;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

endpackage
`default_nettype wire

/* hdl/tdpt_mod_unit.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module tdpt_mod_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [tdpt_pkg::N_BITS-1:0]   dividend,
    input  wire logic [tdpt_pkg::D_BITS-1:0]   divisor,
    output tdpt_pkg::mod_status_t              status
);

    logic [tdpt_pkg::N_BITS-1:0]   shift_reg, shift_next;
    logic [tdpt_pkg::D_BITS-1:0]   divisor_reg, divisor_next;
    logic [tdpt_pkg::D_BITS:0]     rem_reg, rem_next;
    logic [tdpt_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                          running_reg, running_next;
    logic                          done_reg, done_next;
    logic [tdpt_pkg::D_BITS:0]     trial;

    // The partial remainder stays below the divisor, so the shifted value
    // is below twice the divisor and a single subtract restores it.
    assign trial = {rem_reg[tdpt_pkg::D_BITS-1:0], shift_reg[tdpt_pkg::N_BITS-1]};

    always_comb begin
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        running_next = running_reg;
        done_next    = 1'b0;
        if (start) begin
            shift_next   = dividend;
            divisor_next = divisor;
            rem_next     = '0;
            cnt_next     = tdpt_pkg::CNT_BITS'(tdpt_pkg::N_BITS);
            running_next = 1'b1;
        end else if (running_reg) begin
            shift_next = {shift_reg[tdpt_pkg::N_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg}) begin
                rem_next = trial - {1'b0, divisor_reg};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - tdpt_pkg::CNT_BITS'(1);
            if (cnt_reg == tdpt_pkg::CNT_BITS'(1)) begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !running_reg)
        else $error("remainder unit restarted while running");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !running_reg)
        else $error("remainder unit reports done while still running");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (rem_reg < {1'b0, divisor_reg}))
        else $error("partial remainder reached the divisor");

    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(running_reg))
        else $error("done raised without a preceding run");

endmodule
`default_nettype wire

/* hdl/trial_division_prime_test.sv */
// Top level of the trial-division prime test with its stream ports.
//
//  Port group  Dir  Word contents
//  s_*         in   tdata[31:0] candidate (signed)
//  m_*         out  tdata[0] prime_flag, tdata[7:1] zero
//
// Negative, small and even candidates go straight to ST_REPORT, which registers the
// result once the output is free. An odd candidate runs the bit-serial remainder
// unit once for each odd trial divisor up to its square root; a large prime needs
// roughly 23000 trial divisors. Reset clears the sequencer and the result valid
// flag; a new word is taken while a finished result waits on m_tready.
`default_nettype none
module trial_division_prime_test (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [tdpt_pkg::S_TDATA_BITS-1:0]   s_tdata,  // [31:0] candidate
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [tdpt_pkg::M_TDATA_BITS-1:0]   m_tdata   // [0] prime_flag
);

    tdpt_pkg::state_t                state_reg, state_next;
    logic [tdpt_pkg::N_BITS-1:0]     n_reg, n_next;
    logic [tdpt_pkg::D_BITS-1:0]     d_reg, d_next;
    logic [tdpt_pkg::SQ_BITS-1:0]    sq_reg, sq_next;
    logic                            flag_reg, flag_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            m_flag_reg, m_flag_next;
    logic                            mod_start;
    tdpt_pkg::mod_status_t           mod_status;
    logic [tdpt_pkg::VALUE_BITS-1:0] cand;
    logic                            out_free;

    assign cand     = s_tdata[tdpt_pkg::VALUE_BITS-1:0];
    assign s_tready = (state_reg == tdpt_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    tdpt_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (mod_status)
    );

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_flag_next  = m_flag_reg;
        mod_start    = 1'b0;
        case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_next  = cand[tdpt_pkg::N_BITS-1:0];
                    d_next  = tdpt_pkg::D_BITS'(3);
                    sq_next = tdpt_pkg::SQ_BITS'(9);
                    if (cand[tdpt_pkg::VALUE_BITS-1] ||
                        cand[tdpt_pkg::N_BITS-1:0] < tdpt_pkg::N_BITS'(2)) begin
                        flag_next  = 1'b0;
                        state_next = tdpt_pkg::ST_REPORT;
                    end else if (cand[tdpt_pkg::N_BITS-1:0] == tdpt_pkg::N_BITS'(2)) begin
                        flag_next  = 1'b1;
                        state_next = tdpt_pkg::ST_REPORT;
                    end else if (!cand[0]) begin
                        flag_next  = 1'b0;
                        state_next = tdpt_pkg::ST_REPORT;
                    end else begin
                        state_next = tdpt_pkg::ST_CHECK;
                    end
                end
            end
            tdpt_pkg::ST_CHECK: begin
                // Once the divisor squared passes the candidate, no factor is left.
                if (sq_reg > tdpt_pkg::SQ_BITS'(n_reg)) begin
                    flag_next  = 1'b1;
                    state_next = tdpt_pkg::ST_REPORT;
                end else begin
                    mod_start  = 1'b1;
                    state_next = tdpt_pkg::ST_DIVIDE;
                end
            end
            tdpt_pkg::ST_DIVIDE: begin
                if (mod_status.done) begin
                    if (mod_status.zero) begin
                        flag_next  = 1'b0;
                        state_next = tdpt_pkg::ST_REPORT;
                    end else begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        d_next  = d_reg + tdpt_pkg::D_BITS'(2);
                        sq_next = sq_reg + tdpt_pkg::SQ_BITS'({d_reg, 2'b00})
                                  + tdpt_pkg::SQ_BITS'(4);
                        state_next = tdpt_pkg::ST_CHECK;
                    end
                end
            end
            tdpt_pkg::ST_REPORT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_flag_next  = flag_reg;
                    state_next   = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdpt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg      <= n_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
        flag_reg   <= flag_next;
        m_flag_reg <= m_flag_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(tdpt_pkg::M_TDATA_BITS-1){1'b0}}, m_flag_reg};

endmodule
`default_nettype wire

/* tb/sv/trial_division_prime_test_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the trial-division prime test with random stalls on both sides.
module trial_division_prime_test_tb;

    localparam int RANDOM_WORDS = 78;
    // A 31-bit prime needs about 23000 trial divisors.
    localparam int IDLE_LIMIT   = 2_500_000;
    localparam int DRAIN_CYCLES = 60;

    typedef logic [tdpt_pkg::VALUE_BITS-1:0] cand_t;

    typedef struct {
        cand_t cand;
        logic  flag;
    } verdict_t;

    localparam cand_t MOST_NEGATIVE = cand_t'(1) << (tdpt_pkg::VALUE_BITS - 1);
    localparam cand_t MOST_POSITIVE = ~MOST_NEGATIVE;

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [tdpt_pkg::S_TDATA_BITS-1:0] s_tdata  = '0;  // [31:0] candidate
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [tdpt_pkg::M_TDATA_BITS-1:0] m_tdata;        // [0] prime_flag, [7:1] zero

    cand_t    cand_pending[$];
    verdict_t verdict_due[$];

    int error_count      = 0;
    int words_sent       = 0;
    int negatives_sent   = 0;
    int verdicts_checked = 0;
    int primes_seen      = 0;
    int idle_cycles      = 0;
    int send_gap         = 0;
    int stall_left       = 0;
    bit word_taken       = 1'b0;

    trial_division_prime_test dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Primality by trial division over the odd divisors up to the square root.
    function automatic logic prime_by_division(cand_t cand);
        longint unsigned n;
        longint unsigned d;
        n = cand;
        if (cand[tdpt_pkg::VALUE_BITS-1])
            return 1'b0;
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (n % 2 == 0)
            return 1'b0;
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly small values so that the slow divide loop stays short; large words
    // are negative, even or multiples of three, which all finish early.
    function automatic cand_t random_candidate();
        int    r;
        cand_t c;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            c = cand_t'($urandom_range(0, 4095));
        end else if (r < 60) begin
            c = cand_t'($urandom_range(4096, 262143));
        end else if (r < 72) begin
            c = cand_t'($urandom()) | MOST_NEGATIVE;
        end else if (r < 84) begin
            c = cand_t'($urandom()) & MOST_POSITIVE & ~cand_t'(1);
        end else begin
            c = cand_t'($urandom()) & MOST_POSITIVE;
            c = c - (c % 3);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Monitor: record accepted candidates, check result words, watch for a hang.
    always @(posedge aclk) begin : monitor
        verdict_t got;
        bit       moved;
        moved      = 1'b0;
        word_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                got.cand = s_tdata[tdpt_pkg::VALUE_BITS-1:0];
                got.flag = prime_by_division(got.cand);
                verdict_due = {verdict_due, got};
                words_sent++;
                if (got.cand[tdpt_pkg::VALUE_BITS-1])
                    negatives_sent++;
                word_taken = 1'b1;
                moved      = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (verdict_due.size() == 0) begin
                    report_mismatch($sformatf("result word %0h with no candidate outstanding",
                                              m_tdata));
                end else begin
                    got = verdict_due.pop_front();
                    if (m_tdata[0] !== got.flag)
                        report_mismatch($sformatf("candidate %0d: prime_flag %b, expected %b",
                                                  $signed(got.cand), m_tdata[0], got.flag));
                    if (m_tdata[tdpt_pkg::M_TDATA_BITS-1:1] !== '0)
                        report_mismatch($sformatf("candidate %0d: padding bits %0h not zero",
                                                  $signed(got.cand),
                                                  m_tdata[tdpt_pkg::M_TDATA_BITS-1:1]));
                    verdicts_checked++;
                    if (got.flag)
                        primes_seen++;
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] Watchdog: no word moved for %0d cycles, %0d results outstanding.",
                         $time, IDLE_LIMIT, verdict_due.size());
                $display("** trial_division_prime_test: FAILED **");
                $finish;
            end
        end
    end

    // Driver: present pending candidates with random gaps and stall the result side.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || word_taken) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap--;
                end else if (cand_pending.size() != 0) begin
                    s_tdata  <= cand_pending.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        // Bounds of the signed range, small primes and composites, squares of
        // primes where the divisor lands exactly on the root, and large primes.
        cand_pending = '{cand_t'(0), cand_t'(1), cand_t'(2), cand_t'(3), cand_t'(4),
                         cand_t'(5), cand_t'(9), cand_t'(15), cand_t'(25), cand_t'(49),
                         cand_t'(97), cand_t'(121), cand_t'(7919), cand_t'(65537),
                         cand_t'(1022117), cand_t'(1000003), cand_t'(-1), cand_t'(-2),
                         MOST_NEGATIVE, MOST_POSITIVE - 1, cand_t'(32'h5555_5555),
                         MOST_POSITIVE};

        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Hold the sender back until every directed result is in.
        while (cand_pending.size() != 0 || s_tvalid || verdict_due.size() != 0)
            @(negedge aclk);

        @(posedge aclk);
        repeat (RANDOM_WORDS) cand_pending = {cand_pending, random_candidate()};

        while (cand_pending.size() != 0 || s_tvalid || verdict_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (verdict_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_due.size()));

        $display("Sent %0d candidates (%0d negative), checked %0d results, %0d of them prime.",
                 words_sent, negatives_sent, verdicts_checked, primes_seen);
        $display("Directed bounds and small cases, then %0d random words under random stalls.",
                 RANDOM_WORDS);
        if (error_count == 0) begin
            $display("** trial_division_prime_test: PASSED **");
        end else begin
            $display("%0d mismatches.", error_count);
            $display("** trial_division_prime_test: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/tdpt_pkg.sv
hdl/tdpt_mod_unit.sv
hdl/trial_division_prime_test.sv
tb/sv/trial_division_prime_test_tb.sv
